// ===== sv/tga_pkg.sv =====
package tga_pkg;

	localparam int PIXEL_COUNT_BITS = 24;
	localparam int CNT_W = 25;
	localparam logic [32:0] COUNT_CAP = 33'(1) << PIXEL_COUNT_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [1:0] REG_PIXEL_COUNT = 2'd1;
	localparam logic [1:0] REG_COMPRESSED = 2'd2;

	localparam logic [7:0] HDR_RUN_BIT = 8'd128;
	localparam logic [7:0] RUN_BIAS = 8'd127;

	typedef struct packed {
		logic bpp4;
		logic compressed;
		logic [CNT_W-1:0] total;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] want;
		logic is_run;
	} pix_entry_t;

endpackage

// ===== sv/tga_in_if.sv =====
interface tga_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== sv/tga_out_if.sv =====
interface tga_out_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic [7:0] run_length;
	logic image_done;
	logic overrun;

	modport source (output valid, output red, output green, output blue, output alpha,
		output run_length, output image_done, output overrun, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input run_length, input image_done, input overrun, output ready);
endinterface

// ===== sv/tga_cfg_if.sv =====
interface tga_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [24:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/tga_front.sv =====
module tga_front (
	input logic clk,
	input logic arst_n,
	input tga_pkg::cfg_t cfg,
	tga_in_if.sink bytes,
	input logic full,
	output logic push,
	output tga_pkg::pix_entry_t push_data
);

	logic expect_header_q;
	logic packet_is_run_q;
	logic [7:0] packet_left_q;
	logic [1:0] byte_slot_q;
	logic [23:0] pixel_bytes_q;

	logic take;
	logic hdr;
	logic last;
	logic [2:0] bpp;
	logic [7:0] b;
	logic [7:0] want;

	assign bytes.ready = !full;
	assign take = bytes.valid && !full;
	assign b = bytes.data_byte;
	assign bpp = cfg.bpp4 ? 3'd4 : 3'd3;
	assign hdr = cfg.compressed && expect_header_q;
	assign last = ({1'b0, byte_slot_q} + 3'd1) >= bpp;

	always_comb begin
		if (!cfg.compressed) begin
			want = 8'd1;
		end else if (packet_left_q == 8'd0) begin
			want = 8'd1;
		end else begin
			want = packet_left_q;
		end
		push_data.blue = pixel_bytes_q[7:0];
		push_data.green = pixel_bytes_q[15:8];
		push_data.red = cfg.bpp4 ? pixel_bytes_q[23:16] : b;
		push_data.alpha = cfg.bpp4 ? b : 8'd0;
		push_data.want = want;
		push_data.is_run = cfg.compressed && packet_is_run_q;
	end

	assign push = take && !hdr && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			packet_is_run_q <= 1'b0;
			packet_left_q <= '0;
			byte_slot_q <= '0;
			pixel_bytes_q <= '0;
		end else if (take) begin
			if (hdr) begin
				if (b < tga_pkg::HDR_RUN_BIT) begin
					packet_is_run_q <= 1'b0;
					packet_left_q <= b + 8'd1;
				end else begin
					packet_is_run_q <= 1'b1;
					packet_left_q <= b - tga_pkg::RUN_BIAS;
				end
				expect_header_q <= 1'b0;
				byte_slot_q <= '0;
			end else if (!last) begin
				case (byte_slot_q)
					2'd0: pixel_bytes_q[7:0] <= b;
					2'd1: pixel_bytes_q[15:8] <= b;
					2'd2: pixel_bytes_q[23:16] <= b;
					default: pixel_bytes_q <= pixel_bytes_q;
				endcase
				byte_slot_q <= byte_slot_q + 2'd1;
			end else begin
				byte_slot_q <= '0;
				if (cfg.compressed) begin
					if (packet_is_run_q) begin
						packet_left_q <= '0;
						expect_header_q <= 1'b1;
					end else begin
						packet_left_q <= want - 8'd1;
						if (want == 8'd1) begin
							expect_header_q <= 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

// ===== sv/tga_queue.sv =====
module tga_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tga_pkg::pix_entry_t push_data,
	output logic full,
	input logic pop,
	output tga_pkg::pix_entry_t pop_data,
	output logic empty
);

	tga_pkg::pix_entry_t mem_q [tga_pkg::QUEUE_DEPTH];
	logic [tga_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tga_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tga_pkg::QCNT_W-1:0] count_q;

	localparam logic [tga_pkg::QCNT_W-1:0] DEPTH_C = tga_pkg::QCNT_W'(tga_pkg::QUEUE_DEPTH);
	localparam logic [tga_pkg::QPTR_W-1:0] LAST_C = tga_pkg::QPTR_W'(tga_pkg::QUEUE_DEPTH - 1);

	assign full = count_q == DEPTH_C;
	assign empty = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/tga_back.sv =====
module tga_back (
	input logic clk,
	input logic arst_n,
	input tga_pkg::cfg_t cfg,
	input logic empty,
	input tga_pkg::pix_entry_t pop_data,
	output logic pop,
	tga_out_if.source pixels
);

	logic [tga_pkg::CNT_W-1:0] done_q;
	logic finished_q;
	logic out_valid_q;

	logic [tga_pkg::CNT_W-1:0] rem;
	logic [tga_pkg::CNT_W-1:0] done_n;
	logic ge;
	logic big;
	logic over;
	logic fin;
	logic load;
	logic [7:0] run;

	always_comb begin
		ge = done_q >= cfg.total;
		rem = ge ? tga_pkg::CNT_W'(1) : cfg.total - done_q;
		big = tga_pkg::CNT_W'(pop_data.want) > rem;
		over = ge || big;
		if (!pop_data.is_run) begin
			run = 8'd1;
		end else if (big) begin
			run = rem[7:0];
		end else begin
			run = pop_data.want;
		end
		done_n = done_q + tga_pkg::CNT_W'(run);
		fin = (done_n >= cfg.total) || over;
	end

	assign pop = !empty && (finished_q || !out_valid_q || pixels.ready);
	assign load = pop && !finished_q;
	assign pixels.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			finished_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= done_n;
				finished_q <= fin;
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixels.red <= pop_data.red;
			pixels.green <= pop_data.green;
			pixels.blue <= pop_data.blue;
			pixels.alpha <= pop_data.alpha;
			pixels.run_length <= run;
			pixels.image_done <= fin;
			pixels.overrun <= over;
		end
	end

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid |-> pixels.run_length != 8'd0)
		else $error("zero run length on output");

	a_overrun_ends: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && pixels.overrun |-> pixels.image_done)
		else $error("overrun without image done");

	a_done_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> $stable(done_q) && finished_q)
		else $error("pixel count moved after image finished");

	a_open_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && !pixels.image_done |-> done_q < cfg.total)
		else $error("image not flagged done at total");

endmodule

// ===== sv/tga_rle_pixel_decoder_core.sv =====
// TGA run-length pixel decoder.
// bytes: one image-data byte per word (data_byte). In compressed mode each
//   packet opens with a header byte; pixel bytes come as B,G,R(,A).
// pixels: one word per decoded pixel or run: red, green, blue, alpha,
//   run_length, image_done, overrun. A run is one word, not repeated.
// cfg: register writes (index 0 bytes_per_pixel, 1 pixel_count,
//   2 compressed). Always ready; write only while the decoder is idle.
// Throughput: one byte per cycle while the queue is not full. A pixel is
//   written into the queue when its last byte is taken, and the back end
//   then loads it into the output register. The front end tracks packets
//   and assembles pixels, a two-word queue hands them to the back end, which
//   counts pixels against the total and owns the output register.
// When pixels stalls, the queue fills and bytes.ready drops after two more
//   pixels; header and inner pixel bytes keep flowing until then.
// Once the image is done, further bytes are accepted and dropped.
// Reset: bytes_per_pixel 3, pixel_count 1, compressed 1, queue empty,
//   decoder waiting for a packet header.
module tga_rle_pixel_decoder_core (
	input logic clk,
	input logic arst_n,
	tga_in_if.sink bytes,
	tga_out_if.source pixels,
	tga_cfg_if.sink cfg
);

	tga_pkg::cfg_t cfg_q;
	tga_pkg::pix_entry_t push_data;
	tga_pkg::pix_entry_t pop_data;
	logic push;
	logic pop;
	logic full;
	logic empty;
	logic [tga_pkg::CNT_W-1:0] total;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (cfg.data == '0) begin
			total = tga_pkg::CNT_W'(1);
		end else if ({8'd0, cfg.data} > tga_pkg::COUNT_CAP) begin
			total = tga_pkg::COUNT_CAP[tga_pkg::CNT_W-1:0];
		end else begin
			total = cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp4 <= 1'b0;
			cfg_q.compressed <= 1'b1;
			cfg_q.total <= tga_pkg::CNT_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				tga_pkg::REG_BYTES_PER_PIXEL: cfg_q.bpp4 <= cfg.data[2:0] == 3'd4;
				tga_pkg::REG_PIXEL_COUNT: cfg_q.total <= total;
				tga_pkg::REG_COMPRESSED: cfg_q.compressed <= cfg.data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tga_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.bytes(bytes),
		.full(full),
		.push(push),
		.push_data(push_data)
	);

	tga_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	tga_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.empty(empty),
		.pop_data(pop_data),
		.pop(pop),
		.pixels(pixels)
	);

endmodule
